// ===== hdl/pcci_pkg.sv =====
// Shared types, constants and register codes for the clamped-integral PID block.
// Used by the controller, the datapath and the top level; depends on nothing.
package pcci_pkg;

  localparam int IN_W      = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 32;
  localparam int LIM_W     = 14;
  localparam int WIND_W    = 13;
  localparam int ACC_W     = 40;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 21;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int QUO_W     = 33;
  localparam int SUM_W     = 60;
  localparam int TERM_W    = 57;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd983040;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd3276800;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd6554;
  localparam logic [LIM_W-1:0]  OUT_LOW_RST    = 14'h2F99;
  localparam logic [LIM_W-1:0]  OUT_HIGH_RST   = 14'd4199;
  localparam logic [WIND_W-1:0] WINDUP_RST     = 13'd4199;

  localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_INTEG_GAIN,
    CFG_DERIV_GAIN,
    CFG_OUT_LOW,
    CFG_OUT_HIGH,
    CFG_WINDUP_LIMIT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_ED,
    ST_ACC_ADD,
    ST_ACC_CLAMP,
    ST_MUL_IH,
    ST_MUL_IL,
    ST_ACC_I,
    ST_DIV,
    ST_MUL_DL,
    ST_MUL_DH,
    ST_ACC_D,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_ED,
    MS_P,
    MS_IH,
    MS_IL,
    MS_DL,
    MS_DH
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     calc_err;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     acc_clamp;
    logic     sum_init;
    logic     keep_tmp;
    logic     sum_int;
    logic     div_start;
    logic     div_step;
    logic     sum_deriv;
    logic     out_load;
  } pcci_cmd_t;

  typedef struct packed {
    logic zero_dt;
  } pcci_status_t;

endpackage

// ===== hdl/pcci_ctrl.sv =====
// Sequencer for the PID block: steps the datapath through one item.
// Depends on pcci_pkg for the state, command and status types.
module pcci_ctrl
  import pcci_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  pcci_status_t status,
  output pcci_cmd_t    cmd
);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_ERR;
      ST_ERR:       state_next = ST_MUL_ED;
      ST_MUL_ED:    state_next = ST_ACC_ADD;
      ST_ACC_ADD:   state_next = ST_ACC_CLAMP;
      ST_ACC_CLAMP: state_next = ST_MUL_IH;
      ST_MUL_IH:    state_next = ST_MUL_IL;
      ST_MUL_IL:    state_next = ST_ACC_I;
      ST_ACC_I:     state_next = status.zero_dt ? ST_MUL_DL : ST_DIV;
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_MUL_DL;
      end
      ST_MUL_DL:    state_next = ST_MUL_DH;
      ST_MUL_DH:    state_next = ST_ACC_D;
      ST_ACC_D:     state_next = ST_FINISH;
      ST_FINISH:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = pcci_cmd_t'('0);
    cmd.mul_sel = MS_NONE;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ERR:       cmd.calc_err = 1'b1;
      ST_MUL_ED:    cmd.mul_sel = MS_ED;
      ST_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MS_P;
      end
      ST_ACC_CLAMP: begin
        cmd.acc_clamp = 1'b1;
        cmd.sum_init  = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_MUL_IH:    cmd.mul_sel = MS_IH;
      ST_MUL_IL: begin
        cmd.keep_tmp = 1'b1;
        cmd.mul_sel  = MS_IL;
      end
      ST_ACC_I:     cmd.sum_int = 1'b1;
      ST_DIV:       cmd.div_step = 1'b1;
      ST_MUL_DL:    cmd.mul_sel = MS_DL;
      ST_MUL_DH: begin
        cmd.keep_tmp = 1'b1;
        cmd.mul_sel  = MS_DH;
      end
      ST_ACC_D:     cmd.sum_deriv = 1'b1;
      ST_FINISH:    cmd.out_load = !out_valid || out_ready;
      default:      cmd.mul_sel = MS_NONE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

// ===== hdl/pcci_datapath.sv =====
// Datapath of the PID block: registers, shared multiplier, restoring divider,
// integral clamps and output clamp. Depends on pcci_pkg; driven by pcci_ctrl.
module pcci_datapath
  import pcci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  pcci_cmd_t            cmd,
  output pcci_status_t         status,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [3*IN_W-1:0]    in_data,
  output logic [LIM_W-1:0]     out_drive,
  output logic                 out_saturated,
  output logic                 out_zero_time
);

  logic [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
  logic [LIM_W-1:0]  lo_reg, hi_reg;
  logic [WIND_W-1:0] wl_reg;

  logic [IN_W-1:0]    target_q, measured_q, dt_q;
  logic [ERR_W-1:0]   err_q, last_err, diff_mag;
  logic               diff_neg;
  logic [ACC_W-1:0]   integ_acc;
  logic [ACC_W:0]     acc_sum;
  logic [PROD_W-1:0]  prod, tmp;
  logic [SUM_W-1:0]   sum;
  logic [QUO_W-1:0]   div_num;
  logic [IN_W-1:0]    div_rem;

  logic [ERR_W-1:0]   err_new, err_mag;
  logic [ERR_W:0]     diff_new, diff_abs;
  logic [MUL_A_W-1:0] kp_mag, ki_mag, kd_mag, mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [ACC_W-1:0]   acc_mag;
  logic [QUO_W-1:0]   d_mag;
  logic [ACC_W:0]     ed_mag, ed;
  logic [ACC_W:0]     lo_q, hi_q, wl_q, wl_n, a1, a2, a3;
  logic [PROD_W:0]    ki_term;
  logic [PROD_W+17:0] kd_full;
  logic [TERM_W-1:0]  kd_cap;
  logic [IN_W:0]      trial;
  logic               trial_ge;
  logic [35:0]        v, lo_v, hi_v, c1, c2;

  function automatic logic [SUM_W-1:0] signed_term(input logic [TERM_W-1:0] m,
                                                   input logic neg);
    logic [SUM_W-1:0] e;
    e = {{(SUM_W-TERM_W){1'b0}}, m};
    return neg ? ({SUM_W{1'b0}} - e) : e;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_reg <= PROP_GAIN_RST;
      ki_reg <= INTEG_GAIN_RST;
      kd_reg <= DERIV_GAIN_RST;
      lo_reg <= OUT_LOW_RST;
      hi_reg <= OUT_HIGH_RST;
      wl_reg <= WINDUP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PROP_GAIN:    kp_reg <= cfg_data;
        CFG_INTEG_GAIN:   ki_reg <= cfg_data;
        CFG_DERIV_GAIN:   kd_reg <= cfg_data;
        CFG_OUT_LOW:      lo_reg <= cfg_data[LIM_W-1:0];
        CFG_OUT_HIGH:     hi_reg <= cfg_data[LIM_W-1:0];
        CFG_WINDUP_LIMIT: wl_reg <= cfg_data[WIND_W-1:0];
        default:          kp_reg <= kp_reg;
      endcase
    end
  end

  assign status.zero_dt = (dt_q == '0);

  assign err_new  = {target_q[IN_W-1], target_q} - {measured_q[IN_W-1], measured_q};
  assign diff_new = {err_new[ERR_W-1], err_new} - {last_err[ERR_W-1], last_err};
  assign diff_abs = diff_new[ERR_W] ? ({(ERR_W+1){1'b0}} - diff_new) : diff_new;
  assign err_mag  = err_q[ERR_W-1] ? ({ERR_W{1'b0}} - err_q) : err_q;
  assign kp_mag   = kp_reg[GAIN_W-1] ? ({GAIN_W{1'b0}} - kp_reg) : kp_reg;
  assign ki_mag   = ki_reg[GAIN_W-1] ? ({GAIN_W{1'b0}} - ki_reg) : ki_reg;
  assign kd_mag   = kd_reg[GAIN_W-1] ? ({GAIN_W{1'b0}} - kd_reg) : kd_reg;
  assign acc_mag  = integ_acc[ACC_W-1] ? ({ACC_W{1'b0}} - integ_acc) : integ_acc;
  assign d_mag    = status.zero_dt ? '0 : div_num;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_ED: begin
        mul_a = {{(MUL_A_W-ERR_W){1'b0}}, err_mag};
        mul_b = {{(MUL_B_W-IN_W){1'b0}}, dt_q};
      end
      MS_P: begin
        mul_a = kp_mag;
        mul_b = {{(MUL_B_W-ERR_W){1'b0}}, err_mag};
      end
      MS_IH: begin
        mul_a = ki_mag;
        mul_b = acc_mag[36:16];
      end
      MS_IL: begin
        mul_a = ki_mag;
        mul_b = {{(MUL_B_W-16){1'b0}}, acc_mag[15:0]};
      end
      MS_DL: begin
        mul_a = kd_mag;
        mul_b = {{(MUL_B_W-17){1'b0}}, d_mag[16:0]};
      end
      MS_DH: begin
        mul_a = kd_mag;
        mul_b = {{(MUL_B_W-16){1'b0}}, d_mag[QUO_W-1:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign ed_mag = {{(ACC_W+1-33){1'b0}}, prod[32:0]};
  assign ed     = err_q[ERR_W-1] ? ({(ACC_W+1){1'b0}} - ed_mag) : ed_mag;

  assign lo_q = {{3{lo_reg[LIM_W-1]}}, lo_reg, 24'b0};
  assign hi_q = {{3{hi_reg[LIM_W-1]}}, hi_reg, 24'b0};
  assign wl_q = {4'b0, wl_reg, 24'b0};
  assign wl_n = {(ACC_W+1){1'b0}} - wl_q;

  always_comb begin
    a1 = ($signed(acc_sum) < $signed(lo_q)) ? lo_q : acc_sum;
    a2 = ($signed(a1) > $signed(hi_q)) ? hi_q : a1;
    if ($signed(a2) > $signed(wl_q)) begin
      a3 = wl_q;
    end else if ($signed(a2) < $signed(wl_n)) begin
      a3 = wl_n;
    end else begin
      a3 = a2;
    end
  end

  assign ki_term = {1'b0, tmp} + {17'b0, prod[PROD_W-1:16]};
  assign kd_full = {1'b0, prod, 17'b0} + {18'b0, tmp};
  assign kd_cap  = (kd_full > {{(PROD_W+18-TERM_W){1'b0}}, TERM_CAP}) ?
                   TERM_CAP : kd_full[TERM_W-1:0];

  assign trial    = {div_rem, div_num[QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, dt_q});

  assign v    = sum[SUM_W-1:24];
  assign lo_v = {{(36-LIM_W){lo_reg[LIM_W-1]}}, lo_reg};
  assign hi_v = {{(36-LIM_W){hi_reg[LIM_W-1]}}, hi_reg};
  assign c1   = ($signed(v) < $signed(lo_v)) ? lo_v : v;
  assign c2   = ($signed(c1) > $signed(hi_v)) ? hi_v : c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      last_err  <= '0;
    end else begin
      if (cmd.calc_err) last_err <= err_new;
      if (cmd.acc_clamp) integ_acc <= a3[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      target_q   <= in_data[IN_W-1:0];
      measured_q <= in_data[2*IN_W-1:IN_W];
      dt_q       <= in_data[3*IN_W-1:2*IN_W];
    end
    if (cmd.calc_err) begin
      err_q    <= err_new;
      diff_neg <= diff_new[ERR_W];
      diff_mag <= diff_abs[ERR_W-1:0];
    end
    if (cmd.mul_sel != MS_NONE) prod <= mul_a * mul_b;
    if (cmd.keep_tmp) tmp <= prod;
    if (cmd.acc_add) acc_sum <= {integ_acc[ACC_W-1], integ_acc} + ed;
    if (cmd.sum_init) begin
      sum <= signed_term({4'b0, prod}, kp_reg[GAIN_W-1] ^ err_q[ERR_W-1]);
    end else if (cmd.sum_int) begin
      sum <= sum + signed_term({3'b0, ki_term},
                               ki_reg[GAIN_W-1] ^ integ_acc[ACC_W-1]);
    end else if (cmd.sum_deriv) begin
      sum <= sum + signed_term(kd_cap, kd_reg[GAIN_W-1] ^ diff_neg);
    end
    if (cmd.div_start) begin
      div_num <= {diff_mag, 16'b0};
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[QUO_W-2:0], trial_ge};
      div_rem <= trial_ge ? trial[IN_W-1:0] - dt_q : trial[IN_W-1:0];
    end
    if (cmd.out_load) begin
      out_drive     <= c2[LIM_W-1:0];
      out_saturated <= (c2 != v);
      out_zero_time <= status.zero_dt;
    end
  end

endmodule

// ===== hdl/pid_controller_clamped_integral_top.sv =====
// Top level of the clamped-integral PID controller: stream ports and config port.
// Depends on pcci_pkg, pcci_ctrl and pcci_datapath.
//
// One item is taken at a time; the next item can be taken once the sequencer
// has loaded the result and is back in idle. With step_time zero the divide is
// skipped. The 33-step restoring divider forms the derivative, and a single
// 32x21 multiplier is reused for the integral update and the three gain
// terms. The result register lets the next item enter while a result waits
// on m_tready. Configuration writes are always taken (cfg_ready is high) and
// belong in idle periods; indexes above the last register are ignored.
module pid_controller_clamped_integral_top
  import pcci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // target[15:0], measured[31:16], step_time[47:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // drive[13:0], zero pad[15:14]
  output logic [1:0]           m_tuser,   // saturated[0], zero_time[1]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  pcci_cmd_t        cmd;
  pcci_status_t     status;
  logic [LIM_W-1:0] drive;
  logic             saturated, zero_time;

  assign cfg_ready = 1'b1;

  pcci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pcci_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_data       (s_tdata),
    .out_drive     (drive),
    .out_saturated (saturated),
    .out_zero_time (zero_time)
  );

  assign m_tdata = {2'b00, drive};
  assign m_tuser = {zero_time, saturated};

endmodule

// ===== hdl/pcci_checker.sv =====
// Port-level checks for the PID block, bound to the top level.
// Depends only on the top level's port names.
module pcci_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic [1:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken again while an item is in work");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (outstanding == 2'd1 || outstanding == 2'd2))
    else $error("result without a matching input transaction");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind pid_controller_clamped_integral_top pcci_checker u_chk (.*);
